/* design/range_to_cidr_prefix_expander_macros.svh */
// Assertion macros shared by the range-to-CIDR expander RTL.
`ifndef RANGE_TO_CIDR_PREFIX_EXPANDER_MACROS_SVH
`define RANGE_TO_CIDR_PREFIX_EXPANDER_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold on every rising clock edge outside reset.
`define RCPE_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rcpe: assertion violated");
// Condition must never be seen outside reset.
`define RCPE_NEVER(label, clk, rst, cond) \
  `RCPE_ASSERT(label, clk, rst, !(cond))
`else
`define RCPE_ASSERT(label, clk, rst, prop)
`define RCPE_NEVER(label, clk, rst, cond)
`endif

`endif

/* design/rcpe_pkg.sv */
// Types, constants and helper functions of the range-to-CIDR expander.
package rcpe_pkg;

  localparam int ADDR_W = 32;
  localparam int SPAN_W = ADDR_W + 1;
  localparam int PFX_W = 6;
  localparam int HOST_W = 5;
  localparam int RCPE_QUEUE_DEPTH = 2;

  // One range waiting for expansion: first address and address count
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SPAN_W-1:0] span;
  } range_job_t;

  // Set every bit below the most significant one
  function automatic logic [SPAN_W-1:0] smear(logic [SPAN_W-1:0] v);
    logic [SPAN_W-1:0] x;
    x = v;
    x = x | (x >> 1);
    x = x | (x >> 2);
    x = x | (x >> 4);
    x = x | (x >> 8);
    x = x | (x >> 16);
    x = x | (x >> 32);
    return x;
  endfunction

  // Bit index of a one-hot block size, i.e. the host-bit count
  function automatic logic [HOST_W-1:0] host_bits(logic [ADDR_W-1:0] oh);
    logic [HOST_W-1:0] k;
    k = '0;
    for (int i = 0; i < ADDR_W; i++) begin
      if (oh[i]) begin
        k = k | HOST_W'(i);
      end
    end
    return k;
  endfunction

endpackage

/* design/rcpe_range_if.sv */
// Input channel: one inclusive address range per item.
interface rcpe_range_if;
  logic        valid;
  logic        ready;
  logic [31:0] range_start;
  logic [31:0] range_end;

  modport source(output valid, range_start, range_end, input ready);
  modport sink(input valid, range_start, range_end, output ready);
endinterface

/* design/rcpe_block_if.sv */
// Output channel: one CIDR prefix block per item.
interface rcpe_block_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_base;
  logic [5:0]  prefix_length;
  logic        last_block;

  modport source(output valid, block_base, prefix_length, last_block, input ready);
  modport sink(input valid, block_base, prefix_length, last_block, output ready);
endinterface

/* design/rcpe_front.sv */
// Front end: accepts ranges, drops empty ones, computes the address count.
module rcpe_front (
  rcpe_range_if.sink          ranges,
  output logic                push_valid,
  input  logic                push_ready,
  output rcpe_pkg::range_job_t push_job
);
  import rcpe_pkg::*;

  logic non_empty;

  // Empty ranges are taken and discarded
  assign non_empty = ranges.range_start <= ranges.range_end;
  assign ranges.ready = push_ready;
  assign push_valid = ranges.valid && non_empty;

  // Address count end - start + 1, up to 2^32 for the full space
  assign push_job.start = ranges.range_start;
  assign push_job.span = {1'b0, ranges.range_end} - {1'b0, ranges.range_start}
                         + SPAN_W'(1);

endmodule

/* design/rcpe_queue.sv */
// Short FIFO of classified ranges between the front end and the expander.
`include "range_to_cidr_prefix_expander_macros.svh"
module rcpe_queue #(
  parameter int DEPTH = rcpe_pkg::RCPE_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  rcpe_pkg::range_job_t push_job,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output rcpe_pkg::range_job_t pop_job
);
  import rcpe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  range_job_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid = count != '0;
  assign pop_job = entries[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `RCPE_NEVER(a_q_overflow, clk, rst, push_valid && push && count == CNT_W'(DEPTH))
  `RCPE_NEVER(a_q_underflow, clk, rst, pop && count == '0)
  `RCPE_NEVER(a_q_count_range, clk, rst, count > CNT_W'(DEPTH))

endmodule

/* design/rcpe_back.sv */
// Back end: walks one range and emits one prefix block per cycle while the receiver is ready.
`include "range_to_cidr_prefix_expander_macros.svh"
module rcpe_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  rcpe_pkg::range_job_t job,
  rcpe_block_if.source         blocks
);
  import rcpe_pkg::*;

  logic              busy;
  logic [ADDR_W-1:0] cursor;
  logic [SPAN_W-1:0] rem;
  logic              out_valid;
  logic [ADDR_W-1:0] out_base;
  logic [PFX_W-1:0]  out_prefix;
  logic              out_last;

  logic [ADDR_W-1:0] lowbit;
  logic [ADDR_W-1:0] align_oh;
  logic [SPAN_W-1:0] fill;
  logic [SPAN_W-1:0] top_oh;
  logic              fits;
  logic [ADDR_W-1:0] size;
  logic              last;
  logic [PFX_W-1:0]  prefix;
  logic              advance;

  // Largest block allowed by alignment; address zero is capped at /1
  assign lowbit = cursor & (~cursor + ADDR_W'(1));
  assign align_oh = (cursor == '0) ? (ADDR_W'(1) << (ADDR_W - 1)) : lowbit;

  // Largest power of two not above the remaining count
  assign fill = smear(rem);
  assign top_oh = fill ^ (fill >> 1);

  // Take the smaller of the two
  assign fits = |({1'b0, align_oh} & fill);
  assign size = fits ? align_oh : top_oh[ADDR_W-1:0];
  assign last = rem == {1'b0, size};
  assign prefix = PFX_W'(ADDR_W) - PFX_W'(host_bits(size));

  assign advance = busy && (!out_valid || blocks.ready);
  assign job_ready = !busy;

  assign blocks.valid = out_valid;
  assign blocks.block_base = out_base;
  assign blocks.prefix_length = out_prefix;
  assign blocks.last_block = out_last;

  // Range walk control and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (blocks.ready) begin
        out_valid <= 1'b0;
      end
      if (!busy && job_valid) begin
        busy <= 1'b1;
      end else if (advance && last) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (!busy && job_valid) begin
      cursor <= job.start;
      rem <= job.span;
    end else if (advance) begin
      cursor <= cursor + size;
      rem <= rem - {1'b0, size};
    end
    if (advance) begin
      out_base <= cursor;
      out_prefix <= prefix;
      out_last <= last;
    end
  end

  `RCPE_ASSERT(a_rem_nonzero, clk, rst, busy |-> rem != '0)
  `RCPE_ASSERT(a_size_onehot, clk, rst, busy |-> $onehot(size))
  `RCPE_ASSERT(a_base_aligned, clk, rst, out_valid |-> (out_base << out_prefix) == '0)

endmodule

/* design/range_to_cidr_prefix_expander.sv */
// Top level of the address range to CIDR prefix block expander.
// A range passes the range queue and the back-end walk registers before its
// first block is offered. Throughput: one block per cycle while the receiver
// is ready; a range of up to 62 blocks is loaded first and the next is taken
// after its last block. Queued ranges let the input run ahead during a walk.
// Reset: synchronous; empties the range queue and drops any block in flight.
module range_to_cidr_prefix_expander #(
  parameter int QUEUE_DEPTH = rcpe_pkg::RCPE_QUEUE_DEPTH
) (
  input logic          clk,
  input logic          rst,
  rcpe_range_if.sink   ranges,
  rcpe_block_if.source blocks
);
  import rcpe_pkg::*;

  logic       push_valid;
  logic       push_ready;
  range_job_t push_job;
  logic       job_valid;
  logic       job_ready;
  range_job_t job;

  rcpe_front u_front (
    .ranges     (ranges),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  rcpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (job_valid),
    .pop_ready  (job_ready),
    .pop_job    (job)
  );

  rcpe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .blocks    (blocks)
  );

endmodule

/* tb/range_to_cidr_prefix_expander_tb.sv */
// Self-checking testbench of the address range to CIDR prefix block expander.
`timescale 1ns / 100ps

module range_to_cidr_prefix_expander_tb;
  import rcpe_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_BLOCKS = 62;
  localparam int RANDOM_RANGES = 340;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [PFX_W-1:0]  plen;
    logic              last;
  } cidr_block_t;

  // Directed row: range plus blocks typed in by hand when typed is set
  typedef struct packed {
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic              typed;
    logic [1:0]        n_typed;
    cidr_block_t       b0;
    cidr_block_t       b1;
  } range_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

  logic clk;
  logic rst;
  int   cycle_cnt;
  int   mismatch_cnt;
  int   burst_left;
  int   stall_timer;
  rx_mode_t stall_mode;

  cidr_block_t pending_blocks[$];
  range_row_t  range_table[$];

  rcpe_range_if range_ch ();
  rcpe_block_if block_ch ();

  range_to_cidr_prefix_expander u_top (
    .clk    (clk),
    .rst    (rst),
    .ranges (range_ch),
    .blocks (block_ch)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Known values on every input before the first edge
  initial begin
    rst = 1'b1;
    range_ch.valid = 1'b0;
    range_ch.range_start = '0;
    range_ch.range_end = '0;
    block_ch.ready = 1'b0;
  end

  function automatic cidr_block_t blk(logic [ADDR_W-1:0] base, int plen, bit last);
    blk = {base, PFX_W'(plen), last};
  endfunction

  // Append one expected block at the tail of the scoreboard
  function automatic void expect_block(cidr_block_t b);
    pending_blocks.insert(pending_blocks.size(), b);
  endfunction

  // Append one directed row
  function automatic void add_row(range_row_t r);
    range_table.insert(range_table.size(), r);
  endfunction

  // Walk the range: largest aligned block at the cursor that stays inside
  function automatic void expand_range(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
    logic [ADDR_W:0] cur;
    logic [ADDR_W:0] lim;
    logic [ADDR_W:0] nxt;
    logic [ADDR_W:0] sz;
    int   k;
    int   nblk;
    bit   done;
    bit   is_last;
    cur = {1'b0, lo};
    lim = {1'b0, hi};
    nblk = 0;
    done = (lo > hi);
    while (!done && nblk < MAX_BLOCKS) begin
      k = 0;
      for (int j = ADDR_W - 1; j > 0; j--) begin
        sz = (ADDR_W+1)'(1) << j;
        if (k == 0 && (cur & (sz - 1)) == 0 && cur + sz - 1 <= lim) begin
          k = j;
        end
      end
      nxt = cur + ((ADDR_W+1)'(1) << k);
      is_last = (nxt > lim);
      expect_block(blk(cur[ADDR_W-1:0], ADDR_W - k, is_last));
      nblk++;
      cur = nxt;
      done = is_last;
    end
  endfunction

  // Offer one range and hold it until taken
  task automatic send_range(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
    range_ch.valid <= 1'b1;
    range_ch.range_start <= lo;
    range_ch.range_end <= hi;
    do @(posedge clk); while (!range_ch.ready);
  endtask

  // Bursts of back-to-back items, then a random gap
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      burst_left = $urandom_range(0, 20);
      range_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Cycle count and watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: stall mode is drawn anew whenever its random timer runs out
  always @(posedge clk) begin
    if (rst) begin
      block_ch.ready <= 1'b0;
      stall_timer <= 0;
      stall_mode <= RX_OPEN;
    end else begin
      if (stall_timer == 0) begin
        stall_mode <= rx_mode_t'($urandom_range(0, 3));
        stall_timer <= $urandom_range(16, 96);
      end else begin
        stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
        RX_OPEN: begin
          block_ch.ready <= 1'b1;
        end
        RX_COIN: begin
          block_ch.ready <= 1'($urandom_range(0, 1));
        end
        RX_SPARSE: begin
          block_ch.ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          block_ch.ready <= (cycle_cnt[2:0] > 3'd2);
        end
      endcase
    end
  end

  // Compare each block taken against the oldest expectation
  always @(posedge clk) begin
    cidr_block_t want;
    if (!rst && block_ch.valid && block_ch.ready) begin
      if (pending_blocks.size() == 0) begin
        $display("%0t: unexpected block %h/%0d last %b", $time, block_ch.block_base,
                 block_ch.prefix_length, block_ch.last_block);
        mismatch_cnt++;
      end else begin
        want = pending_blocks.pop_front();
        if (block_ch.block_base !== want.base) begin
          $display("%0t: block_base expected %h actual %h", $time, want.base,
                   block_ch.block_base);
          mismatch_cnt++;
        end
        if (block_ch.prefix_length !== want.plen) begin
          $display("%0t: prefix_length expected %0d actual %0d", $time, want.plen,
                   block_ch.prefix_length);
          mismatch_cnt++;
        end
        if (block_ch.last_block !== want.last) begin
          $display("%0t: last_block expected %b actual %b", $time, want.last,
                   block_ch.last_block);
          mismatch_cnt++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    range_row_t row;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W:0]   wide;
    int   nonempty_cnt;
    int   pick;
    bit   paused;
    cycle_cnt = 0;
    mismatch_cnt = 0;
    burst_left = 0;
    nonempty_cnt = 0;
    paused = 1'b0;

    // Edge cases: single addresses, pairs, halves, top of space, full space, empty ranges
    add_row({32'h0000_0000, 32'h0000_0000, 1'b1, 2'd1,
             blk(32'h0000_0000, 32, 1'b1), blk(32'h0, 0, 1'b0)});
    add_row({32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 2'd1,
             blk(32'hFFFF_FFFF, 32, 1'b1), blk(32'h0, 0, 1'b0)});
    add_row({32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 2'd2,
             blk(32'h0000_0000, 1, 1'b0), blk(32'h8000_0000, 1, 1'b1)});
    add_row({32'h0000_0001, 32'h0000_0000, 1'b1, 2'd0,
             blk(32'h0, 0, 1'b0), blk(32'h0, 0, 1'b0)});
    add_row({32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 2'd0,
             blk(32'h0, 0, 1'b0), blk(32'h0, 0, 1'b0)});
    add_row({32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 2'd1,
             blk(32'h8000_0000, 1, 1'b1), blk(32'h0, 0, 1'b0)});
    add_row({32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 2'd1,
             blk(32'h0000_0000, 1, 1'b1), blk(32'h0, 0, 1'b0)});
    add_row({32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 2'd0,
             blk(32'h0, 0, 1'b0), blk(32'h0, 0, 1'b0)});
    add_row({32'h1234_5678, 32'h1234_5678, 1'b1, 2'd1,
             blk(32'h1234_5678, 32, 1'b1), blk(32'h0, 0, 1'b0)});
    add_row({32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 2'd1,
             blk(32'hFFFF_FFFE, 31, 1'b1), blk(32'h0, 0, 1'b0)});
    add_row({32'h0000_0000, 32'h0000_0001, 1'b1, 2'd1,
             blk(32'h0000_0000, 31, 1'b1), blk(32'h0, 0, 1'b0)});
    // Longest walk, walks ending on the top address, odd spans
    add_row({32'h0000_0001, 32'hFFFF_FFFE, 1'b0, 2'd0,
             blk(32'h0, 0, 1'b0), blk(32'h0, 0, 1'b0)});
    add_row({32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 2'd0,
             blk(32'h0, 0, 1'b0), blk(32'h0, 0, 1'b0)});
    add_row({32'h0000_0000, 32'hFFFF_FFFE, 1'b0, 2'd0,
             blk(32'h0, 0, 1'b0), blk(32'h0, 0, 1'b0)});
    add_row({32'hC0A8_0001, 32'hC0A8_00FE, 1'b0, 2'd0,
             blk(32'h0, 0, 1'b0), blk(32'h0, 0, 1'b0)});
    add_row({32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 2'd0,
             blk(32'h0, 0, 1'b0), blk(32'h0, 0, 1'b0)});
    add_row({32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 2'd0,
             blk(32'h0, 0, 1'b0), blk(32'h0, 0, 1'b0)});
    add_row({32'h8000_0001, 32'hFFFF_FFFF, 1'b0, 2'd0,
             blk(32'h0, 0, 1'b0), blk(32'h0, 0, 1'b0)});

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part
    foreach (range_table[i]) begin
      row = range_table[i];
      send_range(row.lo, row.hi);
      if (row.typed) begin
        if (row.n_typed > 0) expect_block(row.b0);
        if (row.n_typed > 1) expect_block(row.b1);
      end else begin
        expand_range(row.lo, row.hi);
      end
      pace_sender();
    end

    // Random part: mostly well-formed ranges of varied shape, some empty
    while (nonempty_cnt < RANDOM_RANGES) begin
      pick = $urandom_range(0, 99);
      lo = $urandom;
      if (pick < 40) begin
        // short span from a random start, clipped at the top address
        mask = ADDR_W'((64'd1 << $urandom_range(0, 31)) - 1);
        wide = {1'b0, lo} + {1'b0, ($urandom & mask)};
        hi = wide[ADDR_W] ? 32'hFFFF_FFFF : wide[ADDR_W-1:0];
      end else if (pick < 58) begin
        hi = $urandom;
      end else if (pick < 72) begin
        // ranges at or near the top of the space
        lo = 32'hFFFF_FFFF - ADDR_W'($urandom & ((32'd1 << $urandom_range(0, 31)) - 1));
        hi = ($urandom_range(0, 2) != 0) ? 32'hFFFF_FFFF : lo + (~lo >> 1);
      end else if (pick < 84) begin
        // exactly one aligned block
        mask = ADDR_W'((64'd1 << $urandom_range(0, 31)) - 1);
        lo = lo & ~mask;
        hi = lo | mask;
      end else if (pick < 94) begin
        // odd ends near both extremes: many blocks
        lo = ADDR_W'($urandom_range(0, 4095)) | 32'd1;
        hi = 32'hFFFF_FFFF - ADDR_W'($urandom_range(0, 4095));
      end else begin
        // empty range, unless the start wraps past the top address
        hi = $urandom_range(0, 32'hFFFF_FFFE);
        lo = hi + 32'd1 + ADDR_W'($urandom & ~hi & 32'h0000_FFFF);
      end
      if (lo <= hi) nonempty_cnt++;
      send_range(lo, hi);
      expand_range(lo, hi);
      pace_sender();
      // Hold off once until everything in flight has come out
      if (!paused && nonempty_cnt >= RANDOM_RANGES / 2) begin
        paused = 1'b1;
        range_ch.valid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge clk);
      end
    end

    range_ch.valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* range_to_cidr_prefix_expander.f */
+incdir+design
design/rcpe_pkg.sv
design/rcpe_range_if.sv
design/rcpe_block_if.sv
design/rcpe_front.sv
design/rcpe_queue.sv
design/rcpe_back.sv
design/range_to_cidr_prefix_expander.sv
tb/range_to_cidr_prefix_expander_tb.sv
